### rtl/ssdf_pkg.sv
// ----------------------------------------------------------------------------
// ssdf_pkg
// Shared types, command bytes, glyph table and divider constants for the
// seven-segment display framer.
// ----------------------------------------------------------------------------
package ssdf_pkg;

  // Request operations
  localparam logic [2:0] OP_SHOW_VALUE = 3'd0;
  localparam logic [2:0] OP_SHOW_RAW   = 3'd1;
  localparam logic [2:0] OP_CLEAR      = 3'd2;
  localparam logic [2:0] OP_ON         = 3'd3;
  localparam logic [2:0] OP_OFF        = 3'd4;

  // Work item kinds passed from front to back
  localparam logic [1:0] KIND_DIGITS = 2'd0;
  localparam logic [1:0] KIND_ON     = 2'd1;
  localparam logic [1:0] KIND_OFF    = 2'd2;

  // Driver command bytes
  localparam logic [7:0] CMD_DATA  = 8'h40;
  localparam logic [7:0] CMD_ADDR  = 8'hC0;
  localparam logic [7:0] CMD_OFF   = 8'h80;
  localparam logic [7:0] CMD_ON    = 8'h88;
  localparam logic [7:0] GLYPH_OFF = 8'h00;

  localparam logic [2:0] BRIGHTNESS_RESET = 3'd4;

  // Frame sequence of a digit write
  localparam logic [2:0] STEP_DATA     = 3'd0;
  localparam logic [2:0] STEP_ADDR     = 3'd1;
  localparam logic [2:0] STEP_SEG_LAST = 3'd5;
  localparam logic [2:0] STEP_LAST     = 3'd6;

  // value mod 10000: q = ((value >> 4) * DIV625_MUL) >> DIV625_SHIFT is exact
  localparam int unsigned    QUOT_W       = 19;
  localparam logic [28:0]    DIV625_MUL   = 29'd439804652;
  localparam int unsigned    DIV625_SHIFT = 38;
  localparam logic [31:0]    MODULUS      = 32'd10000;

  // Quotients of a remainder below 10000 by 1000, 100 and 10
  localparam logic [14:0]    DIV1000_MUL   = 15'd16778;
  localparam int unsigned    DIV1000_SHIFT = 24;
  localparam logic [13:0]    DIV100_MUL    = 14'd10486;
  localparam int unsigned    DIV100_SHIFT  = 20;
  localparam logic [13:0]    DIV10_MUL     = 14'd13108;
  localparam int unsigned    DIV10_SHIFT   = 17;

  // Decoupling queue
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef struct packed {
    logic [1:0]      kind;
    logic [3:0][7:0] segs;   // segs[0] is the leftmost digit
  } entry_t;

  function automatic logic [7:0] glyph(input logic [3:0] code);
    logic [7:0] seg;
    unique case (code)
      4'h0: seg = 8'h3f;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5b;
      4'h3: seg = 8'h4f;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6d;
      4'h6: seg = 8'h7d;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7f;
      4'h9: seg = 8'h6f;
      4'hA: seg = 8'h77;
      4'hB: seg = 8'h7c;
      4'hC: seg = 8'h39;
      4'hD: seg = 8'h5e;
      4'hE: seg = 8'h79;
      4'hF: seg = 8'h71;
      default: seg = GLYPH_OFF;
    endcase
    return seg;
  endfunction

  // Raw digit code: above 15 is blank
  function automatic logic [7:0] encode_raw(input logic [7:0] code);
    logic [7:0] seg;
    if (code[7:4] != 4'd0) begin
      seg = GLYPH_OFF;
    end else begin
      seg = glyph(code[3:0]);
    end
    return seg;
  endfunction

endpackage

### rtl/ssdf_front.sv
// ----------------------------------------------------------------------------
// ssdf_front
// Accepts requests, classifies them and computes the four segment bytes in a
// four-stage pipeline (modulo 10000, decimal split, blanking and encoding).
// ----------------------------------------------------------------------------
module ssdf_front import ssdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [31:0] value,
  input  logic        keep_zeros,
  input  logic [7:0]  digit_a,
  input  logic [7:0]  digit_b,
  input  logic [7:0]  digit_c,
  input  logic [7:0]  digit_d,
  input  logic        q_full,
  output logic        q_wr,
  output entry_t      q_data
);

  logic stall;
  logic accept;

  // stage 1
  logic              v1, is_val1, lz1;
  logic [1:0]        kind1;
  logic [3:0][7:0]   segs1;
  logic [31:0]       val1;
  logic [QUOT_W-1:0] quot1;
  logic [56:0]       prod1;
  logic [1:0]        kind_in;
  logic [3:0][7:0]   segs_in;

  // stage 2
  logic              v2, is_val2, lz2;
  logic [1:0]        kind2;
  logic [3:0][7:0]   segs2;
  logic [31:0]       val2;
  logic [31:0]       qm2;

  // stage 3
  logic              v3, is_val3, lz3;
  logic [1:0]        kind3;
  logic [3:0][7:0]   segs3;
  logic [13:0]       rem3;
  logic [31:0]       diff3;

  // stage 4
  logic              v4, is_val4, lz4;
  logic [1:0]        kind4;
  logic [3:0][7:0]   segs4;
  logic [13:0]       rem4;
  logic [3:0]        q1000_4;
  logic [6:0]        q100_4;
  logic [9:0]        q10_4;
  logic [28:0]       p1000;
  logic [27:0]       p100;
  logic [27:0]       p10;

  // digit assembly
  logic [6:0]        d1_full;
  logic [9:0]        d2_full;
  logic [13:0]       d3_full;
  logic [3:0]        dig0, dig1, dig2, dig3;
  logic              z0, z1, z2;
  logic [3:0][7:0]   segs_val;

  assign stall  = v4 && q_full;
  assign full   = stall;
  assign accept = push && !stall;

  // Classify and encode raw digits on entry
  always_comb begin
    kind_in = KIND_DIGITS;
    segs_in = '0;
    unique case (operation)
      OP_SHOW_RAW: begin
        segs_in[0] = encode_raw(digit_a);
        segs_in[1] = encode_raw(digit_b);
        segs_in[2] = encode_raw(digit_c);
        segs_in[3] = encode_raw(digit_d);
      end
      OP_ON:   kind_in = KIND_ON;
      OP_OFF:  kind_in = KIND_OFF;
      default: kind_in = KIND_DIGITS;
    endcase
  end

  assign prod1 = 57'(value[31:4]) * 57'(DIV625_MUL);
  assign diff3 = val2 - qm2;
  assign p1000 = 29'(rem3) * 29'(DIV1000_MUL);
  assign p100  = 28'(rem3) * 28'(DIV100_MUL);
  assign p10   = 28'(rem3) * 28'(DIV10_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (!stall) begin
      // drop unknown operations at the door
      v1 <= accept && (operation <= OP_OFF);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      kind1   <= kind_in;
      is_val1 <= (operation == OP_SHOW_VALUE);
      lz1     <= keep_zeros;
      segs1   <= segs_in;
      val1    <= value;
      quot1   <= prod1[DIV625_SHIFT +: QUOT_W];

      kind2   <= kind1;
      is_val2 <= is_val1;
      lz2     <= lz1;
      segs2   <= segs1;
      val2    <= val1;
      qm2     <= 32'(quot1) * MODULUS;

      kind3   <= kind2;
      is_val3 <= is_val2;
      lz3     <= lz2;
      segs3   <= segs2;
      rem3    <= diff3[13:0];

      kind4   <= kind3;
      is_val4 <= is_val3;
      lz4     <= lz3;
      segs4   <= segs3;
      rem4    <= rem3;
      q1000_4 <= p1000[DIV1000_SHIFT +: 4];
      q100_4  <= p100[DIV100_SHIFT +: 7];
      q10_4   <= p10[DIV10_SHIFT +: 10];
    end
  end

  // Decimal digits from the quotients, then leading-zero blanking
  always_comb begin
    d1_full = q100_4 - 7'(7'(q1000_4) * 7'd10);
    d2_full = q10_4 - 10'(10'(q100_4) * 10'd10);
    d3_full = rem4 - 14'(14'(q10_4) * 14'd10);
    dig0 = q1000_4;
    dig1 = d1_full[3:0];
    dig2 = d2_full[3:0];
    dig3 = d3_full[3:0];
    z0 = !lz4 && (dig0 == 4'd0);
    z1 = z0 && (dig1 == 4'd0);
    z2 = z1 && (dig2 == 4'd0);
    segs_val[0] = z0 ? GLYPH_OFF : glyph(dig0);
    segs_val[1] = z1 ? GLYPH_OFF : glyph(dig1);
    segs_val[2] = z2 ? GLYPH_OFF : glyph(dig2);
    segs_val[3] = glyph(dig3);
  end

  assign q_wr        = v4 && !q_full;
  assign q_data.kind = kind4;
  assign q_data.segs = is_val4 ? segs_val : segs4;

endmodule

### rtl/ssdf_queue.sv
// ----------------------------------------------------------------------------
// ssdf_queue
// Small register queue of classified work items between front and back.
// ----------------------------------------------------------------------------
module ssdf_queue import ssdf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t wr_data,
  output logic   q_full,
  input  logic   rd,
  output entry_t rd_data,
  output logic   q_empty
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign q_full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

### rtl/ssdf_back.sv
// ----------------------------------------------------------------------------
// ssdf_back
// Walks the head work item through its frames into the result register,
// one per cycle while that register is free or being popped.
// ----------------------------------------------------------------------------
module ssdf_back import ssdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       q_empty,
  output logic       q_rd,
  input  logic [2:0] bright_level,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] frame_byte,
  output logic       start_before,
  output logic       stop_after,
  output logic       last
);

  logic [2:0] step;
  logic       out_valid;
  logic       adv;
  logic       single;
  logic       item_done;
  logic [1:0] seg_idx;
  logic [7:0] on_cmd;
  logic [7:0] byte_next;
  logic       start_next;
  logic       stop_next;
  logic       last_next;

  assign on_cmd    = CMD_ON | {5'd0, bright_level};
  assign single    = (head.kind != KIND_DIGITS);
  assign item_done = single || (step == STEP_LAST);
  assign seg_idx   = step[1:0] - 2'd2;
  assign adv       = !out_valid || pop;
  assign q_rd      = adv && !q_empty && item_done;
  assign empty     = !out_valid;

  always_comb begin
    if (single) begin
      byte_next  = (head.kind == KIND_ON) ? on_cmd : CMD_OFF;
      start_next = 1'b1;
      stop_next  = 1'b1;
      last_next  = 1'b1;
    end else begin
      unique case (step)
        STEP_DATA: begin
          byte_next  = CMD_DATA;
          start_next = 1'b1;
          stop_next  = 1'b1;
          last_next  = 1'b0;
        end
        STEP_ADDR: begin
          byte_next  = CMD_ADDR;
          start_next = 1'b1;
          stop_next  = 1'b0;
          last_next  = 1'b0;
        end
        STEP_LAST: begin
          byte_next  = on_cmd;
          start_next = 1'b1;
          stop_next  = 1'b1;
          last_next  = 1'b1;
        end
        default: begin
          byte_next  = head.segs[seg_idx];
          start_next = 1'b0;
          stop_next  = (step == STEP_SEG_LAST);
          last_next  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= STEP_DATA;
    end else if (adv) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        step <= item_done ? STEP_DATA : step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && !q_empty) begin
      frame_byte   <= byte_next;
      start_before <= start_next;
      stop_after   <= stop_next;
      last         <= last_next;
    end
  end

endmodule

### rtl/seven_segment_display_framer.sv
// ----------------------------------------------------------------------------
// seven_segment_display_framer
// Turns display requests into byte frames for a four-digit seven-segment
// two-wire display driver.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue: drive operation and its fields with push high;
//   the request is taken on a clock edge where full is low. Unknown
//   operations are taken and dropped.
//   Result side is a queue too: while empty is low the oldest frame sits on
//   frame_byte/start_before/stop_after/last; pulse pop to take it.
//   brightness_write loads brightness_data into the level ORed into the
//   display-on command; change it only while the block is idle.
// Path and throughput:
//   With both sides idle the first frame of a request passes the four front
//   pipeline stages, the queue and the result register. A digit write (show
//   value, show raw, clear) is sent as a data command, an address command,
//   four segment bytes and the display-on command; display on/off as one.
//   The front takes one request per cycle until its four-entry queue fills.
// Reset:
//   Synchronous, active high: pipeline, queue and result register empty out,
//   brightness returns to 4.
// Stall:
//   A frame not popped holds the result register; the sequencer, then the
//   queue, then the front pipeline back up in turn, and full rises.
// ----------------------------------------------------------------------------
module seven_segment_display_framer import ssdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [31:0] value,
  input  logic        keep_zeros,
  input  logic [7:0]  digit_a,
  input  logic [7:0]  digit_b,
  input  logic [7:0]  digit_c,
  input  logic [7:0]  digit_d,
  // frame channel
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  frame_byte,
  output logic        start_before,
  output logic        stop_after,
  output logic        last,
  // brightness register
  input  logic        brightness_write,
  input  logic [2:0]  brightness_data
);

  logic [2:0] bright_level;
  logic       q_wr;
  logic       q_rd;
  logic       q_full;
  logic       q_empty;
  entry_t     q_wr_data;
  entry_t     q_head;

  // Hold the brightness level; it is only sampled by the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      bright_level <= BRIGHTNESS_RESET;
    end else if (brightness_write) begin
      bright_level <= brightness_data;
    end
  end

  // Front: accept, classify, compute segment bytes
  ssdf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .value        (value),
    .keep_zeros   (keep_zeros),
    .digit_a      (digit_a),
    .digit_b      (digit_b),
    .digit_c      (digit_c),
    .digit_d      (digit_d),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_data       (q_wr_data)
  );

  // Decouple the two sides so each can stall on its own
  ssdf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd      (q_rd),
    .rd_data (q_head),
    .q_empty (q_empty)
  );

  // Back: advance through the frames of the head item
  ssdf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .q_empty      (q_empty),
    .q_rd         (q_rd),
    .bright_level (bright_level),
    .pop          (pop),
    .empty        (empty),
    .frame_byte   (frame_byte),
    .start_before (start_before),
    .stop_after   (stop_after),
    .last         (last)
  );

endmodule

### rtl/ssdf_checker.sv
// ----------------------------------------------------------------------------
// ssdf_checker
// Port-level checks on the frame channel of the display framer.
// ----------------------------------------------------------------------------
module ssdf_checker import ssdf_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       pop,
  input logic       empty,
  input logic [7:0] frame_byte,
  input logic       start_before,
  input logic       stop_after,
  input logic       last
);

  // Reset leaves no frame waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("frame present right after reset");

  // A waiting frame holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(frame_byte) && $stable(last)
      && $stable(start_before) && $stable(stop_after))
    else $error("waiting frame changed before pop");

  // The final frame of a request is a complete command
  a_last_framed: assert property (@(posedge clk) disable iff (rst)
    !empty && last |-> start_before && stop_after)
    else $error("last frame without start and stop");

  // Only the address command opens a transfer that stays open
  a_addr_open: assert property (@(posedge clk) disable iff (rst)
    !empty && start_before && !stop_after |-> frame_byte == CMD_ADDR)
    else $error("open transfer not started by address command");

endmodule

bind seven_segment_display_framer ssdf_checker u_ssdf_checker (
  .clk          (clk),
  .rst          (rst),
  .pop          (pop),
  .empty        (empty),
  .frame_byte   (frame_byte),
  .start_before (start_before),
  .stop_after   (stop_after),
  .last         (last)
);
